[src/mcconv_pkg.sv]
package mcconv_pkg;

  // default sizes of the stores
  localparam int DEF_MAX_KERNEL = 5;
  localparam int DEF_MAX_IN_CH  = 16;
  localparam int DEF_MAX_OUT_CH = 16;
  localparam int DEF_MAX_WIDTH  = 64;
  localparam int ROW_LIMIT      = 1024;

  // item kinds
  localparam logic [1:0] MODE_PIXEL  = 2'd0;
  localparam logic [1:0] MODE_WEIGHT = 2'd1;
  localparam logic [1:0] MODE_BIAS   = 2'd2;

  // register indexes
  localparam logic [2:0] REG_IN_ROWS     = 3'd0;
  localparam logic [2:0] REG_IN_COLS     = 3'd1;
  localparam logic [2:0] REG_KERNEL_ROWS = 3'd2;
  localparam logic [2:0] REG_KERNEL_COLS = 3'd3;
  localparam logic [2:0] REG_STRIDE_ROWS = 3'd4;
  localparam logic [2:0] REG_STRIDE_COLS = 3'd5;
  localparam logic [2:0] REG_IN_CHANNELS = 3'd6;
  localparam logic [2:0] REG_OUT_CHANNELS = 3'd7;

  typedef struct packed {
    logic [1:0]          mode;
    logic signed [15:0]  sample;
    logic [3:0]          target_out_channel;
    logic [3:0]          target_in_channel;
    logic [2:0]          tap_row;
    logic [2:0]          tap_col;
  } in_item_t;

  typedef struct packed {
    logic [3:0]          result_channel;
    logic [9:0]          result_row;
    logic [5:0]          result_col;
    logic signed [15:0]  result_value;
    logic                last_of_run;
  } out_item_t;

  // broadcast controls to the cell row
  typedef struct packed {
    logic start;
    logic wload;
    logic bload;
    logic capture;
    logic shift;
  } cell_ctl_t;

endpackage

[src/mcconv_cell.sv]
module mcconv_cell import mcconv_pkg::*; #(
  parameter int DEPTH = 400,
  parameter int AW    = 9,
  parameter int ACC_W = 42
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cell_ctl_t                ctl,
  input  logic                     sel,
  input  logic [AW-1:0]            wr_addr,
  input  logic signed [15:0]       wr_data,
  input  logic                     s_valid_in,
  input  logic signed [15:0]       s_pix_in,
  input  logic [AW-1:0]            s_addr_in,
  output logic                     s_valid_out,
  output logic signed [15:0]       s_pix_out,
  output logic [AW-1:0]            s_addr_out,
  input  logic [15:0]              shift_in,
  output logic [15:0]              shift_out
);

  localparam logic signed [ACC_W-1:0] QMAX = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] QMIN = -ACC_W'(32768);
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(2048);

  logic signed [15:0]      wmem [DEPTH];
  logic signed [15:0]      wq;
  logic signed [15:0]      bias;
  logic signed [31:0]      prod;
  logic                    pv;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] rnd;
  logic signed [ACC_W-1:0] q;
  logic [15:0]             sat;
  logic [15:0]             outr;

  // weights of this output channel
  always_ff @(posedge clk) begin
    if (ctl.wload && sel) begin
      wmem[wr_addr] <= wr_data;
    end
    wq <= wmem[s_addr_in];
  end

  // round half up, then clip to q8.8
  always_comb begin
    rnd = acc + HALF;
    q   = rnd >>> 12;
    if (q > QMAX) begin
      sat = 16'h7fff;
    end else if (q < QMIN) begin
      sat = 16'h8000;
    end else begin
      sat = q[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid_out <= 1'b0;
      pv          <= 1'b0;
    end else begin
      s_valid_out <= s_valid_in;
      pv          <= s_valid_out;
    end
    s_pix_out  <= s_pix_in;
    s_addr_out <= s_addr_in;
    prod       <= wq * s_pix_out;
    if (ctl.bload && sel) begin
      bias <= wr_data;
    end
    if (ctl.start) begin
      acc <= $signed({{(ACC_W-28){bias[15]}}, bias, 12'b0});
    end else if (pv) begin
      acc <= acc + ACC_W'(prod);
    end
    if (ctl.capture) begin
      outr <= sat;
    end else if (ctl.shift) begin
      outr <= shift_in;
    end
  end

  assign shift_out = outr;

endmodule

[src/multichannel_conv2d_strided.sv]
// an item is taken only while the window sequencer rests; a pixel that closes a window
//   holds off further items while the sequencer waits for the result row to drain, walks the
//   taps and lets the cell row settle; results then leave one a cycle unless out_stall holds them;
//   the single line store read port feeds the cell row one tap a cycle
// reset: synchronous, active high; clears position, control and registers to defaults,
//   stores hold undefined contents until written
module multichannel_conv2d_strided import mcconv_pkg::*; #(
  parameter int MAX_KERNEL = DEF_MAX_KERNEL,
  parameter int MAX_IN_CH  = DEF_MAX_IN_CH,
  parameter int MAX_OUT_CH = DEF_MAX_OUT_CH,
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int KW     = $clog2(MAX_KERNEL + 1);
  localparam int SLW    = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int ICW    = (MAX_IN_CH > 1) ? $clog2(MAX_IN_CH) : 1;
  localparam int ICNW   = $clog2(MAX_IN_CH + 1);
  localparam int OCW    = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1;
  localparam int OCNW   = $clog2(MAX_OUT_CH + 1);
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int CNW    = $clog2(MAX_WIDTH + 1);
  localparam int WDEPTH = MAX_IN_CH * MAX_KERNEL * MAX_KERNEL;
  localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int LDEPTH = MAX_KERNEL * MAX_WIDTH * MAX_IN_CH;
  localparam int LAW    = $clog2(LDEPTH);
  localparam int ACC_W  = 33 + $clog2(WDEPTH);
  localparam int FL_END = MAX_OUT_CH + 3;
  localparam int FLW    = $clog2(FL_END + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WAIT  = 2'd1;
  localparam logic [1:0] S_FEED  = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  function automatic logic [31:0] clampu(input logic [31:0] v, input int hi);
    logic [31:0] r;
    if (v == 32'd0) begin
      r = 32'd1;
    end else if (v > 32'(hi)) begin
      r = 32'(hi);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // raw configuration registers
  logic [10:0] r_rows;
  logic [6:0]  r_cols;
  logic [2:0]  r_kr, r_kc;
  logic [3:0]  r_sr, r_sc;
  logic [4:0]  r_nic, r_noc;

  // values in use after clamping
  logic [10:0]     rows_e;
  logic [CNW-1:0]  cols_e;
  logic [KW-1:0]   kr_e, kc_e;
  logic [3:0]      sr_e, sc_e;
  logic [ICNW-1:0] nic_e;
  logic [OCNW-1:0] noc_e;

  // frame position and window phase
  logic [9:0]     pos_row;
  logic [CW-1:0]  pos_col;
  logic [ICW-1:0] pos_ch;
  logic [SLW-1:0] pos_slot;
  logic [3:0]     rph, cph;
  logic [9:0]     orow;
  logic [CW-1:0]  ocol;

  logic ch_last, col_last, row_last, row_ok, col_ok, win;
  logic acc_in, acc_px, acc_cfg;
  logic [31:0] bslot_t, wr_l_t, rd_l_t, wr_w_t, rd_w_t;

  // window sequencer
  logic [1:0]     state;
  logic [SLW-1:0] base_slot;
  logic [CW-1:0]  base_col;
  logic [9:0]     win_row;
  logic [CW-1:0]  win_col;
  logic [ICW-1:0] f_ic;
  logic [SLW-1:0] f_ti, f_tj, f_slot;
  logic           tj_last, ti_last, ic_last;
  logic [FLW-1:0] fl;

  // line store
  logic signed [15:0] lmem [LDEPTH];
  logic signed [15:0] lq;
  logic [LAW-1:0]     wr_laddr, rd_laddr;
  logic [WAW-1:0]     rd_waddr, feed_addr, wr_waddr;
  logic               feed_v;

  // output side
  logic [OCNW-1:0] out_left;
  logic [OCW-1:0]  out_ch;
  logic [9:0]      out_row;
  logic [CW-1:0]   out_col;

  cell_ctl_t ctl;
  logic      w_in_range, b_in_range;
  logic [MAX_OUT_CH-1:0] sel;

  logic                     sv    [MAX_OUT_CH+1];
  logic signed [15:0]       spix  [MAX_OUT_CH+1];
  logic [WAW-1:0]           saddr [MAX_OUT_CH+1];
  logic [15:0]              sh    [MAX_OUT_CH+1];

  assign rows_e = 11'(clampu(32'(r_rows), ROW_LIMIT));
  assign cols_e = CNW'(clampu(32'(r_cols), MAX_WIDTH));
  assign kr_e   = KW'(clampu(32'(r_kr), MAX_KERNEL));
  assign kc_e   = KW'(clampu(32'(r_kc), MAX_KERNEL));
  assign sr_e   = 4'(clampu(32'(r_sr), 15));
  assign sc_e   = 4'(clampu(32'(r_sc), 15));
  assign nic_e  = ICNW'(clampu(32'(r_nic), MAX_IN_CH));
  assign noc_e  = OCNW'(clampu(32'(r_noc), MAX_OUT_CH));

  // input transfer only while the sequencer rests
  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign acc_in    = in_valid && !in_stall;
  assign acc_px    = acc_in && (in_data.mode == MODE_PIXEL);
  assign acc_cfg   = cfg_valid && cfg_ready;

  assign ch_last  = (32'(pos_ch) + 32'd1) >= 32'(nic_e);
  assign col_last = (32'(pos_col) + 32'd1) >= 32'(cols_e);
  assign row_last = (32'(pos_row) + 32'd1) >= 32'(rows_e);
  assign row_ok   = ((32'(pos_row) + 32'd1) >= 32'(kr_e)) && (rph == 4'd0);
  assign col_ok   = ((32'(pos_col) + 32'd1) >= 32'(kc_e)) && (cph == 4'd0);
  assign win      = ch_last && row_ok && col_ok;

  // line slot of the window's top row, modulo the kernel depth
  always_comb begin
    bslot_t = 32'(pos_slot) + 32'd1 + 32'(MAX_KERNEL) - 32'(kr_e);
    if (bslot_t >= 32'(MAX_KERNEL)) begin
      bslot_t = bslot_t - 32'(MAX_KERNEL);
    end
  end

  always_comb begin
    wr_l_t = (32'(pos_slot) * 32'(MAX_WIDTH) + 32'(pos_col)) * 32'(MAX_IN_CH) + 32'(pos_ch);
    rd_l_t = (32'(f_slot) * 32'(MAX_WIDTH) + 32'(base_col) + 32'(f_tj)) * 32'(MAX_IN_CH)
             + 32'(f_ic);
    rd_w_t = (32'(f_ic) * 32'(MAX_KERNEL) + 32'(f_ti)) * 32'(MAX_KERNEL) + 32'(f_tj);
    wr_w_t = (32'(in_data.target_in_channel) * 32'(MAX_KERNEL) + 32'(in_data.tap_row))
             * 32'(MAX_KERNEL) + 32'(in_data.tap_col);
  end

  assign wr_laddr = wr_l_t[LAW-1:0];
  assign rd_laddr = rd_l_t[LAW-1:0];
  assign rd_waddr = rd_w_t[WAW-1:0];
  assign wr_waddr = wr_w_t[WAW-1:0];

  // configuration writes and the frame position
  always_ff @(posedge clk) begin
    if (rst) begin
      r_rows   <= 11'd64;
      r_cols   <= 7'd64;
      r_kr     <= 3'd3;
      r_kc     <= 3'd3;
      r_sr     <= 4'd1;
      r_sc     <= 4'd1;
      r_nic    <= 5'd1;
      r_noc    <= 5'd1;
      pos_row  <= '0;
      pos_col  <= '0;
      pos_ch   <= '0;
      pos_slot <= '0;
      rph      <= '0;
      cph      <= '0;
      orow     <= '0;
      ocol     <= '0;
    end else if (acc_cfg) begin
      case (cfg_index)
        REG_IN_ROWS:      r_rows <= cfg_data[10:0];
        REG_IN_COLS:      r_cols <= cfg_data[6:0];
        REG_KERNEL_ROWS:  r_kr   <= cfg_data[2:0];
        REG_KERNEL_COLS:  r_kc   <= cfg_data[2:0];
        REG_STRIDE_ROWS:  r_sr   <= cfg_data[3:0];
        REG_STRIDE_COLS:  r_sc   <= cfg_data[3:0];
        REG_IN_CHANNELS:  r_nic  <= cfg_data[4:0];
        REG_OUT_CHANNELS: r_noc  <= cfg_data[4:0];
        default:          r_rows <= r_rows;
      endcase
      // any write restarts the frame
      pos_row  <= '0;
      pos_col  <= '0;
      pos_ch   <= '0;
      pos_slot <= '0;
      rph      <= '0;
      cph      <= '0;
      orow     <= '0;
      ocol     <= '0;
    end else if (acc_px) begin
      if (!ch_last) begin
        pos_ch <= pos_ch + 1'b1;
      end else begin
        pos_ch <= '0;
        if (!col_last) begin
          pos_col <= pos_col + 1'b1;
          // column phase against the stride, once the first window fits
          if ((32'(pos_col) + 32'd2) <= 32'(kc_e)) begin
            cph  <= '0;
            ocol <= '0;
          end else if (({1'b0, cph} + 5'd1) == {1'b0, sc_e}) begin
            cph  <= '0;
            ocol <= ocol + 1'b1;
          end else begin
            cph <= cph + 4'd1;
          end
        end else begin
          pos_col <= '0;
          cph     <= '0;
          ocol    <= '0;
          if (row_last) begin
            pos_row  <= '0;
            pos_slot <= '0;
            rph      <= '0;
            orow     <= '0;
          end else begin
            pos_row  <= pos_row + 10'd1;
            pos_slot <= (32'(pos_slot) + 32'd1 == 32'(MAX_KERNEL)) ? '0 : pos_slot + 1'b1;
            if ((32'(pos_row) + 32'd2) <= 32'(kr_e)) begin
              rph  <= '0;
              orow <= '0;
            end else if (({1'b0, rph} + 5'd1) == {1'b0, sr_e}) begin
              rph  <= '0;
              orow <= orow + 10'd1;
            end else begin
              rph <= rph + 4'd1;
            end
          end
        end
      end
    end
  end

  // line store: pixel write, tap read
  always_ff @(posedge clk) begin
    if (acc_px) begin
      lmem[wr_laddr] <= in_data.sample;
    end
    lq <= lmem[rd_laddr];
  end

  assign tj_last = (32'(f_tj) + 32'd1) >= 32'(kc_e);
  assign ti_last = (32'(f_ti) + 32'd1) >= 32'(kr_e);
  assign ic_last = (32'(f_ic) + 32'd1) >= 32'(nic_e);

  // window sequencer: wait for the result row to drain, walk the taps, let the row settle
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      feed_v <= 1'b0;
      f_ic   <= '0;
      f_ti   <= '0;
      f_tj   <= '0;
      f_slot <= '0;
      fl     <= '0;
    end else begin
      feed_v <= (state == S_FEED);
      case (state)
        S_IDLE: begin
          if (acc_px && win) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          f_ic   <= '0;
          f_ti   <= '0;
          f_tj   <= '0;
          f_slot <= base_slot;
          if (out_left == '0) begin
            state <= S_FEED;
          end
        end
        S_FEED: begin
          if (!tj_last) begin
            f_tj <= f_tj + 1'b1;
          end else begin
            f_tj <= '0;
            if (!ti_last) begin
              f_ti   <= f_ti + 1'b1;
              f_slot <= (32'(f_slot) + 32'd1 == 32'(MAX_KERNEL)) ? '0 : f_slot + 1'b1;
            end else begin
              f_ti   <= '0;
              f_slot <= base_slot;
              f_ic   <= f_ic + 1'b1;
              if (ic_last) begin
                state <= S_FLUSH;
                fl    <= '0;
              end
            end
          end
        end
        S_FLUSH: begin
          fl <= fl + 1'b1;
          if (fl == FLW'(FL_END)) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // window origin, held while the taps are walked
  always_ff @(posedge clk) begin
    feed_addr <= rd_waddr;
    if (acc_px && win) begin
      base_slot <= SLW'(bslot_t);
      base_col  <= CW'(32'(pos_col) + 32'd1 - 32'(kc_e));
      win_row   <= orow;
      win_col   <= ocol;
    end
  end

  // weight and bias loads out of range are dropped
  assign w_in_range = (32'(in_data.target_out_channel) < 32'(MAX_OUT_CH))
                   && (32'(in_data.target_in_channel) < 32'(MAX_IN_CH))
                   && (32'(in_data.tap_row) < 32'(MAX_KERNEL))
                   && (32'(in_data.tap_col) < 32'(MAX_KERNEL));
  assign b_in_range = 32'(in_data.target_out_channel) < 32'(MAX_OUT_CH);

  always_comb begin
    ctl.start   = (state == S_WAIT) && (out_left == '0);
    ctl.wload   = acc_in && (in_data.mode == MODE_WEIGHT) && w_in_range;
    ctl.bload   = acc_in && (in_data.mode == MODE_BIAS) && b_in_range;
    ctl.capture = (state == S_FLUSH) && (fl == FLW'(FL_END));
    ctl.shift   = out_valid && !out_stall;
  end

  // row of cells, one per output channel; taps move one cell a cycle
  assign sv[0]              = feed_v;
  assign spix[0]            = lq;
  assign saddr[0]           = feed_addr;
  assign sh[MAX_OUT_CH]     = 16'd0;

  for (genvar k = 0; k < MAX_OUT_CH; k++) begin : g_cell
    assign sel[k] = (32'(in_data.target_out_channel) == 32'(k));
    mcconv_cell #(
      .DEPTH (WDEPTH),
      .AW    (WAW),
      .ACC_W (ACC_W)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .sel         (sel[k]),
      .wr_addr     (wr_waddr),
      .wr_data     (in_data.sample),
      .s_valid_in  (sv[k]),
      .s_pix_in    (spix[k]),
      .s_addr_in   (saddr[k]),
      .s_valid_out (sv[k+1]),
      .s_pix_out   (spix[k+1]),
      .s_addr_out  (saddr[k+1]),
      .shift_in    (sh[k+1]),
      .shift_out   (sh[k])
    );
  end

  // results leave through cell 0, channel 0 first
  always_ff @(posedge clk) begin
    if (rst) begin
      out_left <= '0;
      out_ch   <= '0;
    end else if (ctl.capture) begin
      out_left <= noc_e;
      out_ch   <= '0;
    end else if (ctl.shift) begin
      out_left <= out_left - 1'b1;
      out_ch   <= out_ch + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      out_row <= win_row;
      out_col <= win_col;
    end
  end

  assign out_valid = (out_left != '0);

  always_comb begin
    out_data.result_channel = 4'(out_ch);
    out_data.result_row     = out_row;
    out_data.result_col     = 6'(out_col);
    out_data.result_value   = sh[0];
    out_data.last_of_run    = (out_left == OCNW'(1));
  end

endmodule

[src/mcconv_chk.sv]
module mcconv_chk import mcconv_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input in_item_t    in_data,
  input logic        out_valid,
  input logic        out_stall,
  input out_item_t   out_data,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [2:0]  cfg_index,
  input logic [15:0] cfg_data
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("result changed while stalled");

  // a run always opens on channel 0
  a_run_start: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (out_data.result_channel == 4'd0))
    else $error("run did not open on channel 0");

  // channels follow one another within a run
  a_run_step: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !out_data.last_of_run) |=>
      (out_valid && out_data.result_channel == $past(out_data.result_channel) + 4'd1))
    else $error("run broken between channels");

  // nothing follows the last transfer of a run at once
  a_run_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && out_data.last_of_run) |=> !out_valid)
    else $error("result right after end of run");

endmodule

bind multichannel_conv2d_strided mcconv_chk u_chk (.*);
